### hdl/cfd_pkg.sv
// Shared types and constants for the command frame deframer.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package cfd_pkg;

	// Default payload buffer capacity in bytes.
	localparam int MAX_PAYLOAD_DEF = 64;

	// Fixed field widths of the result channel.
	localparam int BYTE_W  = 8;
	localparam int STAT_W  = 2;
	localparam int INDEX_W = 6;

	// Header characters of a request frame.
	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
	localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_CSUM     = 2'd1,
		STAT_OVERSIZE = 2'd2
	} stat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  take_size;    // latch the size byte and seed the checksum
		logic  take_cmd;     // latch the command byte, clear the byte count
		logic  take_body;    // absorb one payload byte
		logic  drain_start;  // point the drain index at the first payload byte
		logic  rd_en;        // read the buffer at the drain index
		logic  drain_next;   // step the drain index
		logic  load_result;  // load a single summary result into the output register
		logic  load_drain;   // load a payload result into the output register
		stat_t res_status;   // status of a summary result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_dollar;
		logic is_m;
		logic is_lt;
		logic body_done;   // all declared payload bytes have been taken
		logic oversize;    // declared size exceeds the buffer
		logic xor_ok;      // incoming byte equals the running checksum
		logic size_zero;
		logic drain_last;  // drain index points at the final payload byte
	} sts_t;

endpackage

`default_nettype wire

### hdl/command_frame_deframer.sv
// Top level of the command frame deframer: controller, datapath and buffer.
// Depends on cfd_pkg, cfd_ctrl, cfd_dp (which holds the cfd_ram buffer).
// The input channel (in_valid, in_ready, rx_byte) carries one received serial
// byte per request. The block looks for frames of the form
// '$' 'M' '<' size command payload checksum, where the checksum is the XOR of
// size, command and every payload byte. Bytes outside a frame are dropped, and
// a wrong header byte sends the parser back to idle.
// The output channel (out_valid, out_ready and the result fields) carries one
// request per payload byte of a good frame, with byte_valid set and last on
// the final byte. An empty frame, a checksum mismatch or a size above
// MAX_PAYLOAD gives one request with byte_valid clear and last set.
// A summary result is visible the cycle after the checksum byte. A good frame
// drains each payload byte with a buffer read and then an output register
// load, with input held off; its first result follows the buffer read of the
// first payload byte, once the output register is free.
// When the receiver stalls, the output register holds its result; parsing of
// header and payload bytes goes on, and only a checksum byte or the next drain
// step waits for the register to free up.
// Reset (arst_n low) returns the parser to idle and empties the output
// register; the buffer contents need no clearing.
`default_nettype none

module command_frame_deframer #(
	parameter int MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [cfd_pkg::BYTE_W-1:0]   rx_byte,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [cfd_pkg::STAT_W-1:0]   status,
	output logic      [cfd_pkg::BYTE_W-1:0]   command,
	output logic      [cfd_pkg::BYTE_W-1:0]   payload_size,
	output logic      [cfd_pkg::INDEX_W-1:0]  byte_index,
	output logic      [cfd_pkg::BYTE_W-1:0]   payload_byte,
	output logic                              byte_valid,
	output logic                              last
);

	import cfd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The controller sequences header parsing, frame end and buffer drain.
	cfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath keeps the frame fields, the checksum, the payload buffer
	// and the output register.
	cfd_dp #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (rx_byte),
		.cmd         (cmd),
		.sts         (sts),
		.status      (status),
		.command     (command),
		.payload_size(payload_size),
		.byte_index  (byte_index),
		.payload_byte(payload_byte),
		.byte_valid  (byte_valid),
		.last        (last)
	);

endmodule

`default_nettype wire

### hdl/cfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/cfd_ctrl.sv
// Controller state machine of the command frame deframer.
// Depends on cfd_pkg for the command and status structs.
`default_nettype none

module cfd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire cfd_pkg::sts_t sts,
	output cfd_pkg::cmd_t      cmd
);

	import cfd_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_HDR_M  = 8'b0000_0010,
		ST_HDR_LT = 8'b0000_0100,
		ST_SIZE   = 8'b0000_1000,
		ST_CMD    = 8'b0001_0000,
		ST_BODY   = 8'b0010_0000,
		ST_RD     = 8'b0100_0000,
		ST_LOAD   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   in_fire;

	assign slot_free = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		unique case (state_q)
			ST_RD, ST_LOAD: in_ready = 1'b0;
			ST_BODY:        in_ready = !sts.body_done || slot_free;
			default:        in_ready = 1'b1;
		endcase
	end

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.res_status = STAT_OK;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && sts.is_dollar) begin
					state_d = ST_HDR_M;
				end
			end
			ST_HDR_M: begin
				if (in_fire) begin
					state_d = sts.is_m ? ST_HDR_LT : ST_IDLE;
				end
			end
			ST_HDR_LT: begin
				if (in_fire) begin
					state_d = sts.is_lt ? ST_SIZE : ST_IDLE;
				end
			end
			ST_SIZE: begin
				if (in_fire) begin
					cmd.take_size = 1'b1;
					state_d       = ST_CMD;
				end
			end
			ST_CMD: begin
				if (in_fire) begin
					cmd.take_cmd = 1'b1;
					state_d      = ST_BODY;
				end
			end
			ST_BODY: begin
				if (in_fire) begin
					priority if (!sts.body_done) begin
						cmd.take_body = 1'b1;
					end else if (sts.oversize) begin
						cmd.load_result = 1'b1;
						cmd.res_status  = STAT_OVERSIZE;
						state_d         = ST_IDLE;
					end else if (!sts.xor_ok) begin
						cmd.load_result = 1'b1;
						cmd.res_status  = STAT_CSUM;
						state_d         = ST_IDLE;
					end else if (sts.size_zero) begin
						cmd.load_result = 1'b1;
						cmd.res_status  = STAT_OK;
						state_d         = ST_IDLE;
					end else begin
						cmd.drain_start = 1'b1;
						state_d         = ST_RD;
					end
				end
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				if (slot_free) begin
					cmd.load_drain = 1'b1;
					if (sts.drain_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.drain_next = 1'b1;
						state_d        = ST_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result || cmd.load_drain) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The output register is only overwritten once its result has gone.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_result || cmd.load_drain) |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while full");

	// No input byte is taken while the payload buffer drains.
	a_drain_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_LOAD) |-> !in_ready)
		else $error("input accepted during drain");

	// Every buffer read is followed by a load wait step.
	a_rd_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |=> (state_q == ST_LOAD))
		else $error("buffer read not followed by load");

endmodule

`default_nettype wire

### hdl/cfd_dp.sv
// Datapath of the command frame deframer: frame registers, checksum,
// payload buffer and output register. Depends on cfd_pkg and cfd_ram.
`default_nettype none

module cfd_dp #(
	parameter int MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [cfd_pkg::BYTE_W-1:0]   rx_byte,
	input  wire cfd_pkg::cmd_t                cmd,
	output cfd_pkg::sts_t                     sts,
	output logic      [cfd_pkg::STAT_W-1:0]   status,
	output logic      [cfd_pkg::BYTE_W-1:0]   command,
	output logic      [cfd_pkg::BYTE_W-1:0]   payload_size,
	output logic      [cfd_pkg::INDEX_W-1:0]  byte_index,
	output logic      [cfd_pkg::BYTE_W-1:0]   payload_byte,
	output logic                              byte_valid,
	output logic                              last
);

	import cfd_pkg::*;

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [BYTE_W-1:0] MAX_SIZE = BYTE_W'(MAX_PAYLOAD);

	logic [BYTE_W-1:0]  frame_size_q;
	logic [BYTE_W-1:0]  frame_cmd_q;
	logic [BYTE_W-1:0]  xor_q;
	logic [BYTE_W-1:0]  count_q;
	logic [INDEX_W-1:0] drain_idx_q;
	logic [BYTE_W-1:0]  rd_data;
	logic               oversize;

	assign oversize = frame_size_q > MAX_SIZE;

	assign sts.is_dollar  = rx_byte == CH_DOLLAR;
	assign sts.is_m       = rx_byte == CH_M;
	assign sts.is_lt      = rx_byte == CH_LT;
	assign sts.body_done  = count_q == frame_size_q;
	assign sts.oversize   = oversize;
	assign sts.xor_ok     = xor_q == rx_byte;
	assign sts.size_zero  = frame_size_q == '0;
	assign sts.drain_last = (BYTE_W'(drain_idx_q) + 8'd1) == frame_size_q;

	cfd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_PAYLOAD)
	) u_buf (
		.clk  (clk),
		.we   (cmd.take_body && !oversize),
		.waddr(count_q[AW-1:0]),
		.wdata(rx_byte),
		.re   (cmd.rd_en),
		.raddr(drain_idx_q[AW-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.take_size) begin
			frame_size_q <= rx_byte;
			xor_q        <= rx_byte;
		end
		if (cmd.take_cmd) begin
			frame_cmd_q <= rx_byte;
			xor_q       <= xor_q ^ rx_byte;
			count_q     <= '0;
		end
		if (cmd.take_body) begin
			xor_q   <= xor_q ^ rx_byte;
			count_q <= count_q + 8'd1;
		end
		if (cmd.drain_start) begin
			drain_idx_q <= '0;
		end else if (cmd.drain_next) begin
			drain_idx_q <= drain_idx_q + INDEX_W'(1);
		end
		if (cmd.load_result) begin
			status       <= cmd.res_status;
			command      <= frame_cmd_q;
			payload_size <= frame_size_q;
			byte_index   <= '0;
			payload_byte <= '0;
			byte_valid   <= 1'b0;
			last         <= 1'b1;
		end else if (cmd.load_drain) begin
			status       <= STAT_OK;
			command      <= frame_cmd_q;
			payload_size <= frame_size_q;
			byte_index   <= drain_idx_q;
			payload_byte <= rd_data;
			byte_valid   <= 1'b1;
			last         <= sts.drain_last;
		end
	end

	// A drain read never reaches beyond the declared payload.
	a_drain_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (BYTE_W'(drain_idx_q) < frame_size_q && !oversize))
		else $error("drain index outside payload");

	// Payload bytes are only absorbed while the frame body is incomplete.
	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_body |-> (count_q < frame_size_q))
		else $error("payload byte taken past declared size");

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for command_frame_deframer: a table of directed frames,
// then random frame traffic, each result checked against an in-bench frame parser or a typed-in result.
// Depends on cfd_pkg and the command_frame_deframer RTL; reads no files.

module tb_top;
	import cfd_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 8;
	localparam int CAPACITY       = MAX_PAYLOAD_DEF;
	// Random part stops once this many bytes have gone in, directed ones included.
	localparam int TOTAL_ITEMS    = 350;
	localparam int IDLE_PCT       = 12;
	// A good frame drains with a buffer read and a register load per byte after the
	// checksum; this is a generous margin for anything still in flight after the last result.
	localparam int SETTLE_CYCLES  = 32;
	localparam int WATCHDOG_LIMIT = 2000;

	// Where the parser stands within a request frame.
	typedef enum logic [2:0] {
		SEEK_DOLLAR,
		SEEK_M,
		SEEK_LT,
		TAKE_SIZE,
		TAKE_CMD,
		TAKE_BODY
	} hunt_t;

	// One result as it appears on the output channel.
	typedef struct packed {
		stat_t              status;
		logic [BYTE_W-1:0]  command;
		logic [BYTE_W-1:0]  payload_size;
		logic [INDEX_W-1:0] byte_index;
		logic [BYTE_W-1:0]  payload_byte;
		logic               byte_valid;
		logic               last;
	} frame_result_t;

	// One row of the directed table: a byte, how often it is sent back to back,
	// and optionally the single result that its acceptance must produce.
	typedef struct {
		logic [BYTE_W-1:0] rx;
		int unsigned       reps;
		logic              typed;
		frame_result_t     result;
	} stim_row_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [BYTE_W-1:0]   rx_byte  = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STAT_W-1:0]   status;
	logic [BYTE_W-1:0]   command;
	logic [BYTE_W-1:0]   payload_size;
	logic [INDEX_W-1:0]  byte_index;
	logic [BYTE_W-1:0]  payload_byte;
	logic                byte_valid;
	logic                last;

	// These travel alongside rx_byte: when stim_typed is set, the accepted byte
	// must give exactly the typed-in result instead of what the parser predicts.
	logic                stim_typed  = 1'b0;
	frame_result_t       stim_expect = '0;

	// Results the block owes us, oldest first.
	frame_result_t       owed_results [$];
	// Scratch list filled by the parser for one accepted byte.
	frame_result_t       frame_out [$];
	stim_row_t           directed_rows [$];
	int unsigned         mismatch_count = 0;
	int unsigned         idle_pct = IDLE_PCT;
	// Bytes accepted so far, over the directed and the random part.
	int unsigned         bytes_sent = 0;

	// Parser state, kept apart from the block's own.
	hunt_t               hunt    = SEEK_DOLLAR;
	logic [BYTE_W-1:0]   p_size  = '0;
	logic [BYTE_W-1:0]   p_cmd   = '0;
	logic [BYTE_W-1:0]   p_xor   = '0;
	logic [BYTE_W-1:0]   p_count = '0;
	logic [BYTE_W-1:0]   p_buf [CAPACITY];

	command_frame_deframer #(
		.MAX_PAYLOAD (CAPACITY)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.command      (command),
		.payload_size (payload_size),
		.byte_index   (byte_index),
		.payload_byte (payload_byte),
		.byte_valid   (byte_valid),
		.last         (last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// A single-result frame end: empty frame, bad checksum or oversize.
	function automatic frame_result_t summary(input stat_t s, input logic [BYTE_W-1:0] cmd,
			input logic [BYTE_W-1:0] size);
		frame_result_t r;
		r              = '0;
		r.status       = s;
		r.command      = cmd;
		r.payload_size = size;
		r.last         = 1'b1;
		return r;
	endfunction

	function automatic void add_row(input logic [BYTE_W-1:0] rx, input int unsigned reps = 1,
			input logic typed = 1'b0, input frame_result_t result = '0);
		stim_row_t row;
		row.rx     = rx;
		row.reps   = reps;
		row.typed  = typed;
		row.result = result;
		directed_rows.push_back(row);
	endfunction

	// Advance the parser by one received byte and list the results that the
	// byte releases in frame_out. Only the checksum byte releases anything.
	function automatic void parse_rx_byte(input logic [BYTE_W-1:0] c);
		frame_result_t r;
		int            k;
		case (hunt)
			SEEK_DOLLAR: begin
				if (c == CH_DOLLAR)
					hunt = SEEK_M;
			end
			// A wrong header byte drops back to idle and is not looked at again,
			// so a second '$' does not restart the header.
			SEEK_M: hunt = (c == CH_M) ? SEEK_LT : SEEK_DOLLAR;
			SEEK_LT: hunt = (c == CH_LT) ? TAKE_SIZE : SEEK_DOLLAR;
			TAKE_SIZE: begin
				p_size = c;
				p_xor  = c;
				hunt   = TAKE_CMD;
			end
			TAKE_CMD: begin
				p_cmd   = c;
				p_xor   = p_xor ^ c;
				p_count = '0;
				hunt    = TAKE_BODY;
			end
			TAKE_BODY: begin
				if (p_count < p_size) begin
					p_xor = p_xor ^ c;
					// Oversize frames are swallowed without being stored.
					if (p_size <= CAPACITY)
						p_buf[p_count[INDEX_W-1:0]] = c;
					p_count = p_count + 1'b1;
				end else begin
					if (p_size > CAPACITY) begin
						frame_out.push_back(summary(STAT_OVERSIZE, p_cmd, p_size));
					end else if (p_xor != c) begin
						frame_out.push_back(summary(STAT_CSUM, p_cmd, p_size));
					end else if (p_size == 0) begin
						frame_out.push_back(summary(STAT_OK, p_cmd, p_size));
					end else begin
						for (k = 0; k < int'(p_size); k++) begin
							r              = '0;
							r.status       = STAT_OK;
							r.command      = p_cmd;
							r.payload_size = p_size;
							r.byte_index   = k[INDEX_W-1:0];
							r.payload_byte = p_buf[k];
							r.byte_valid   = 1'b1;
							r.last         = (k + 1 == int'(p_size));
							frame_out.push_back(r);
						end
					end
					p_count = '0;
					hunt    = SEEK_DOLLAR;
				end
			end
			default: hunt = SEEK_DOLLAR;
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
			input logic [BYTE_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Offer one byte as a request, after a random number of idle cycles, and
	// return at the edge where it is taken. in_valid is written at most once
	// per edge, so a back-to-back byte keeps valid high without a glitch.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed = 1'b0,
			input frame_result_t result = '0);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		rx_byte     <= b;
		stim_typed  <= typed;
		stim_expect <= result;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Hold the sender off until the block has delivered everything it owes.
	// The first edge lets the monitor book the results of the last byte.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	// The receiver stalls at random, in step with the sender's idle rate.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= idle_pct);
	end

	// Both channels are sampled at the edge; every driver uses nonblocking
	// assignments, so the values seen here are the ones the block saw.
	// The output side is checked before the input side books new results.
	always @(posedge clk) begin : monitor
		frame_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (owed_results.size() == 0) begin
				$error("result with no expectation: command 0x%0h, index %0d",
					command, byte_index);
				mismatch_count++;
			end else begin
				want = owed_results.pop_front();
				check_field("status", want.status, status);
				check_field("command", want.command, command);
				check_field("payload_size", want.payload_size, payload_size);
				check_field("byte_index", want.byte_index, byte_index);
				check_field("payload_byte", want.payload_byte, payload_byte);
				check_field("byte_valid", want.byte_valid, byte_valid);
				check_field("last", want.last, last);
			end
		end
		if (arst_n && in_valid && in_ready) begin
			frame_out.delete();
			parse_rx_byte(rx_byte);
			if (stim_typed)
				owed_results.push_back(stim_expect);
			else
				foreach (frame_out[i])
					owed_results.push_back(frame_out[i]);
		end
	end

	// Ends the run if neither channel moves a request for too long, which is
	// also how a result that never comes shows up.
	initial begin : watchdog
		int unsigned silent;
		silent = 0;
		while (silent < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				silent = 0;
			else
				silent++;
		end
		$error("no request moved for %0d cycles, %0d results still owed",
			WATCHDOG_LIMIT, owed_results.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		int unsigned       frame_no;
		int unsigned       kind;
		int unsigned       size;
		int unsigned       r;
		logic [BYTE_W-1:0] cmd;
		logic [BYTE_W-1:0] csum;
		logic [BYTE_W-1:0] b;

		// Directed frames. Only frame ends that can be read off directly carry a
		// typed result; the mixed-content frame is left to the parser.
		// Empty frame straight after reset, command at its top value.
		add_row(CH_DOLLAR);
		add_row(CH_M);
		add_row(CH_LT);
		add_row(8'h00);
		add_row(8'hFF);
		add_row(8'hFF, 1, 1'b1, summary(STAT_OK, 8'hFF, 8'h00));
		// A second '$' is a wrong header byte and must not restart the header,
		// so the 'M' '<' that follow are dropped in idle.
		add_row(CH_DOLLAR);
		add_row(CH_DOLLAR);
		add_row(CH_M);
		add_row(CH_LT);
		// Wrong byte after 'M'.
		add_row(CH_DOLLAR);
		add_row(CH_M);
		add_row(CH_DOLLAR);
		// Checksum mismatch: the sum would be 0xAB.
		add_row(CH_DOLLAR);
		add_row(CH_M);
		add_row(CH_LT);
		add_row(8'h01);
		add_row(8'h00);
		add_row(8'hAA);
		add_row(8'h00, 1, 1'b1, summary(STAT_CSUM, 8'h00, 8'h01));
		// Good frame whose command and payload look like header characters.
		add_row(CH_DOLLAR);
		add_row(CH_M);
		add_row(CH_LT);
		add_row(8'h02);
		add_row(CH_DOLLAR);
		add_row(CH_M);
		add_row(CH_LT);
		add_row(8'h57);
		// Oversize frame one byte above the buffer: the body and the checksum
		// byte are swallowed, the checksum itself does not matter.
		add_row(CH_DOLLAR);
		add_row(CH_M);
		add_row(CH_LT);
		add_row(8'(CAPACITY + 1));
		add_row(8'h80);
		add_row(8'h5A, CAPACITY + 1);
		add_row(8'h00, 1, 1'b1, summary(STAT_OVERSIZE, 8'h80, 8'(CAPACITY + 1)));

		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			repeat (directed_rows[i].reps)
				send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].result);
		wait_for_drain();

		// Random part: mostly well-formed frames with random content, plus some
		// line noise and broken headers. A full-buffer frame is placed early so
		// that it always occurs.
		frame_no = 0;
		while (bytes_sent < TOTAL_ITEMS) begin
			// One long stretch with neither side idling.
			idle_pct = (bytes_sent >= 160 && bytes_sent < 280) ? 0 : IDLE_PCT;
			kind = $urandom_range(0, 99);
			if (frame_no == 2)
				kind = 99;
			if (kind < 8) begin
				// Noise between frames; a '$' here would eat the next header.
				repeat ($urandom_range(1, 5)) begin
					do b = 8'($urandom); while (b == CH_DOLLAR);
					send_byte(b);
				end
			end else if (kind < 16) begin
				send_byte(CH_DOLLAR);
				if ($urandom_range(0, 1)) begin
					send_byte(CH_M);
					do b = 8'($urandom); while (b == CH_LT);
				end else begin
					do b = 8'($urandom); while (b == CH_M);
				end
				send_byte(b);
			end else begin
				r = $urandom_range(0, 99);
				if (frame_no == 2)
					size = CAPACITY;
				else if (r < 55)
					size = $urandom_range(0, 6);
				else if (r < 80)
					size = $urandom_range(7, CAPACITY - 2);
				else if (r < 92)
					size = $urandom_range(CAPACITY - 1, CAPACITY + 1);
				else
					size = $urandom_range(CAPACITY + 2, CAPACITY + 12);
				cmd  = 8'($urandom);
				csum = 8'(size) ^ cmd;
				send_byte(CH_DOLLAR);
				send_byte(CH_M);
				send_byte(CH_LT);
				send_byte(8'(size));
				send_byte(cmd);
				repeat (size) begin
					b    = 8'($urandom);
					csum = csum ^ b;
					send_byte(b);
				end
				if ($urandom_range(0, 99) < 15)
					csum = csum ^ 8'($urandom_range(1, 255));
				send_byte(csum);
			end
			frame_no++;
			// Let the output side run dry once in the middle of the traffic.
			if (frame_no == 5)
				wait_for_drain();
		end

		wait_for_drain();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### files.f
hdl/cfd_pkg.sv
hdl/cfd_ram.sv
hdl/cfd_ctrl.sv
hdl/cfd_dp.sv
hdl/command_frame_deframer.sv
dv/tb_top.sv
